// ===== hdl/ss_pkg.sv =====
package ss_pkg;

	localparam int CAPACITY   = 32;
	localparam int KEY_BITS   = 32;
	localparam int COUNT_BITS = $clog2(CAPACITY + 1);

	typedef logic signed [KEY_BITS-1:0] key_t;
	typedef logic [COUNT_BITS-1:0]      count_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_NEXT   = 2'd2,
		OP_PREV   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_PRESENT      = 3'd1,
		ST_ABSENT       = 3'd2,
		ST_NO_NEIGHBOUR = 3'd3,
		ST_FULL         = 3'd4
	} status_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic capture;   // latch compare flags against the bus key
		logic insert;    // open a gap at the insert point, shift right
		logic remove;    // close the gap at the match, shift left
	} cmd_t;

endpackage

// ===== hdl/ss_cell.sv =====
module ss_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  ss_pkg::cmd_t  cmd,
	input  ss_pkg::key_t  bus_key,
	input  ss_pkg::key_t  left_key,
	input  logic          left_valid,
	input  logic          left_lt,
	input  ss_pkg::key_t  right_key,
	input  logic          right_valid,
	output ss_pkg::key_t  key_q,
	output logic          valid_q,
	output logic          lt_q,
	output logic          eq_q
);

	// compare flags, taken when a word is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (cmd.capture) begin
			lt_q <= valid_q && (key_q < bus_key);
			eq_q <= valid_q && (key_q == bus_key);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.insert && !lt_q) begin
			valid_q <= left_lt ? 1'b1 : left_valid;
		end else if (cmd.remove && !lt_q) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && !lt_q) begin
			key_q <= left_lt ? bus_key : left_key;
		end else if (cmd.remove && !lt_q) begin
			key_q <= right_key;
		end
	end

endmodule

// ===== hdl/sorted_set_engine.sv =====
// sorted_set_engine keeps up to ss_pkg::CAPACITY distinct signed keys in
// ascending order in a chain of cells, one key per cell, cell 0 holding the
// smallest. Each input word carries an operation (insert, delete, next
// larger, next smaller) and a key, and yields exactly one result word with a
// status, the neighbour found by a lookup, and the count, smallest and
// largest keys and empty flag after the operation. When a word is accepted
// every cell compares its key against the input key; once the result register
// is free, the cells shift by one place toward or away from the insert or
// delete point and the result register is loaded in the same step. A new word
// is not accepted until the one in flight has been applied; a waiting result
// does not block acceptance of the next word, which then holds in its compare
// stage until the output register frees. Reset empties the set at once.
module sorted_set_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           operation,
	input  ss_pkg::key_t         key,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output ss_pkg::key_t         neighbour,
	output ss_pkg::count_t       count,
	output ss_pkg::key_t         smallest,
	output ss_pkg::key_t         largest,
	output logic                 is_empty
);

	localparam int N = ss_pkg::CAPACITY;

	// word in flight
	logic            busy_q;
	ss_pkg::op_t     op_q;
	ss_pkg::key_t    key_q;
	ss_pkg::count_t  count_q;

	// result register
	logic            out_valid_q;
	ss_pkg::status_t status_q;
	ss_pkg::key_t    neighbour_q;

	// chain taps
	ss_pkg::key_t    cell_key [N];
	logic [N-1:0]    cell_valid;
	logic [N-1:0]    cell_lt;
	logic [N-1:0]    cell_eq;

	logic            accept;
	logic            apply;
	logic            found;
	logic            full;
	logic            do_insert;
	logic            do_remove;
	ss_pkg::cmd_t    cmd;
	ss_pkg::key_t    bus_key;
	ss_pkg::key_t    succ_key;
	ss_pkg::key_t    pred_key;
	logic            succ_hit;
	logic            pred_hit;
	ss_pkg::key_t    tail_key;
	ss_pkg::status_t status_d;
	ss_pkg::key_t    neighbour_d;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	// shift-and-result step of a word, held back while the last result is still unread
	assign apply    = busy_q && (!out_valid_q || out_ready);

	// input key for the compare, latched key while shifting in
	assign bus_key = busy_q ? key_q : key;

	assign found     = |cell_eq;
	assign full      = (count_q == ss_pkg::count_t'(N));
	assign do_insert = apply && (op_q == ss_pkg::OP_INSERT) && !found && !full;
	assign do_remove = apply && (op_q == ss_pkg::OP_DELETE) && found;

	always_comb begin
		cmd         = '0;
		cmd.capture = accept;
		cmd.insert  = do_insert;
		cmd.remove  = do_remove;
	end

	// the chain: each cell sees the key and valid flag of both neighbours and the
	// compare flag of its left one; the head acts as if a smaller key stood left of it
	for (genvar i = 0; i < N; i++) begin : g_cell
		ss_pkg::key_t lk, rk;
		logic         lv, llt, rv;

		if (i == 0) begin : g_head
			assign lk  = cell_key[i];
			assign lv  = 1'b1;
			assign llt = 1'b1;
		end else begin : g_left
			assign lk  = cell_key[i-1];
			assign lv  = cell_valid[i-1];
			assign llt = cell_lt[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign rk = cell_key[i];
			assign rv = 1'b0;
		end else begin : g_right
			assign rk = cell_key[i+1];
			assign rv = cell_valid[i+1];
		end

		ss_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.bus_key     (bus_key),
			.left_key    (lk),
			.left_valid  (lv),
			.left_lt     (llt),
			.right_key   (rk),
			.right_valid (rv),
			.key_q       (cell_key[i]),
			.valid_q     (cell_valid[i]),
			.lt_q        (cell_lt[i]),
			.eq_q        (cell_eq[i])
		);
	end

	// one-hot picks of the neighbours of the matching cell and of the last
	// valid cell
	always_comb begin
		succ_key = '0;
		pred_key = '0;
		succ_hit = 1'b0;
		pred_hit = 1'b0;
		tail_key = '0;
		for (int i = 0; i < N; i++) begin
			if (i > 0 && cell_eq[i-1] && cell_valid[i]) begin
				succ_key = succ_key | cell_key[i];
				succ_hit = 1'b1;
			end
			if (i < N - 1 && cell_eq[i+1]) begin
				pred_key = pred_key | cell_key[i];
				pred_hit = 1'b1;
			end
			if (cell_valid[i] && (i == N - 1 || !cell_valid[(i + 1) % N])) begin
				tail_key = tail_key | cell_key[i];
			end
		end
	end

	always_comb begin
		status_d    = ss_pkg::ST_OK;
		neighbour_d = '0;
		unique case (op_q)
			ss_pkg::OP_INSERT: begin
				if (found) begin
					status_d = ss_pkg::ST_PRESENT;
				end else if (full) begin
					status_d = ss_pkg::ST_FULL;
				end
			end
			ss_pkg::OP_DELETE: begin
				if (!found) begin
					status_d = ss_pkg::ST_ABSENT;
				end
			end
			ss_pkg::OP_NEXT: begin
				if (!found) begin
					status_d = ss_pkg::ST_ABSENT;
				end else if (!succ_hit) begin
					status_d = ss_pkg::ST_NO_NEIGHBOUR;
				end else begin
					neighbour_d = succ_key;
				end
			end
			ss_pkg::OP_PREV: begin
				if (!found) begin
					status_d = ss_pkg::ST_ABSENT;
				end else if (!pred_hit) begin
					status_d = ss_pkg::ST_NO_NEIGHBOUR;
				end else begin
					neighbour_d = pred_key;
				end
			end
			default: begin
				status_d = ss_pkg::ST_ABSENT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (apply) begin
				busy_q <= 1'b0;
			end

			if (apply) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (do_insert) begin
				count_q <= count_q + ss_pkg::count_t'(1);
			end else if (do_remove) begin
				count_q <= count_q - ss_pkg::count_t'(1);
			end
		end
	end

	// word payload and result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= ss_pkg::op_t'(operation);
			key_q <= key;
		end
		if (apply) begin
			status_q    <= status_d;
			neighbour_q <= neighbour_d;
		end
	end

	// set summary straight from the chain, which holds still until the
	// result word is taken
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign neighbour = neighbour_q;
	assign count     = count_q;
	assign smallest  = cell_valid[0] ? cell_key[0] : '0;
	assign largest   = tail_key;
	assign is_empty  = !cell_valid[0];

endmodule
